>>> hdl/eai_pkg.sv
// Shared constants and types for the eased angle interpolator.
package eai_pkg;

    // Field widths and fixed-point format.
    localparam int ANGLE_BITS = 16;
    localparam int COUNT_BITS = 16;
    localparam int FRAC_BITS  = 16;

    // Derived widths of the datapath.
    localparam int PT_BITS   = ANGLE_BITS + 1;          // endpoint with one extra turn
    localparam int T_BITS    = FRAC_BITS + 1;           // t and s, range 0..one
    localparam int NUM_BITS  = COUNT_BITS + FRAC_BITS;  // dividend count << FRAC_BITS
    localparam int STEP_BITS = $clog2(NUM_BITS);
    localparam int MA_BITS   = 2 * T_BITS;              // multiplier operand A
    localparam int MB_BITS   = FRAC_BITS + 2;           // multiplier operand B
    localparam int P_BITS    = MA_BITS + MB_BITS;       // product
    localparam int ACC_BITS  = PT_BITS + T_BITS;        // mix accumulator

    // Configuration register indexes.
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DURATION = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TARGET   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_AXIS     = 2'd2;

    // Item function codes.
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL_TT,
        ST_MUL_S,
        ST_MUL_MA,
        ST_MUL_MB,
        ST_MIX,
        ST_DONE
    } t_state;

endpackage

>>> hdl/eased_angle_interpolator_top.sv
// Eased angle interpolator: sequencer around a serial divider and one shared multiplier.
//
// Usage: configuration registers (duration, target_angle, axis) are written through the
// i_cfg_valid / o_cfg_ready port, which is always ready; write them only while idle.
// Items enter on i_valid when o_stall is low. A start item (func 0) captures the current
// angle and picks the shorter way round to the target; a tick item (func 1) advances the
// frame counter. Every item gives exactly one result on o_valid, taken when i_stall is low.
//
// Sequence: a start item, a tick before any start, and a tick past the duration go straight
// from acceptance to the done state. A tick that computes an angle runs the restoring divider
// for t (one quotient bit per cycle), then four passes through the shared multiplier (t*t,
// times 3-2t, and the two mix terms) and one accumulate.
// The block takes one item at a time; o_stall is high from acceptance until the result is
// moved into the output register. A result waiting in the output register does not block
// the next item; only the move of a new result waits for the output register to drain.
// When the receiver stalls, the output payload holds steady.
// Reset (synchronous, active low) clears the registers, the counter and the started flag,
// and empties the output register.
module eased_angle_interpolator_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input item channel.
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_func,
    input  logic [eai_pkg::ANGLE_BITS-1:0] i_current_angle,
    // Result item channel.
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [eai_pkg::ANGLE_BITS-1:0] o_angle,
    output logic                          o_angle_valid,
    output logic                          o_finished,
    output logic                          o_axis_out,
    // Configuration write channel.
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [eai_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [eai_pkg::COUNT_BITS-1:0] i_cfg_data
);
    import eai_pkg::*;

    localparam logic [PT_BITS-1:0]  FULL_TURN = PT_BITS'(1) << ANGLE_BITS;
    localparam logic [ANGLE_BITS-1:0] HALF_TURN = ANGLE_BITS'(1) << (ANGLE_BITS - 1);
    localparam logic [T_BITS-1:0]   FRAC_ONE  = T_BITS'(1) << FRAC_BITS;
    localparam logic [MB_BITS-1:0]  THREE_ONE = MB_BITS'(3) << FRAC_BITS;
    localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(NUM_BITS - 1);

    // Registers.
    t_state                  r_state, n_state;
    logic [COUNT_BITS-1:0]   r_duration;
    logic [ANGLE_BITS-1:0]   r_target;
    logic                    r_axis;
    logic [PT_BITS-1:0]      r_start, n_start;
    logic [PT_BITS-1:0]      r_end, n_end;
    logic [COUNT_BITS-1:0]   r_count, n_count;
    logic                    r_started, n_started;
    logic [NUM_BITS-1:0]     r_num, n_num;
    logic [COUNT_BITS-1:0]   r_rem, n_rem;
    logic [T_BITS-1:0]       r_quo, n_quo;
    logic [STEP_BITS-1:0]    r_step, n_step;
    logic [P_BITS-1:0]       r_prod, n_prod;
    logic [T_BITS-1:0]       r_s, n_s;
    logic [ACC_BITS-1:0]     r_acc, n_acc;
    logic [ANGLE_BITS-1:0]   r_res_angle, n_res_angle;
    logic                    r_res_avalid, n_res_avalid;
    logic                    r_res_fin, n_res_fin;
    logic                    r_out_valid, n_out_valid;
    logic [ANGLE_BITS-1:0]   r_out_angle, n_out_angle;
    logic                    r_out_avalid, n_out_avalid;
    logic                    r_out_fin, n_out_fin;
    logic                    r_out_axis, n_out_axis;

    // Combinational helpers.
    logic                    in_take;
    logic                    out_free;
    logic [COUNT_BITS:0]     trial;
    logic                    trial_ge;
    logic [COUNT_BITS-1:0]   tick_cnt;
    logic [ANGLE_BITS-1:0]   gap_up, gap_down;
    logic [MA_BITS-1:0]      mul_a;
    logic [MB_BITS-1:0]      mul_b;
    logic [P_BITS-1:0]       mul_p;
    logic [ACC_BITS-1:0]     mix_sum;

    assign o_stall     = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_take     = i_valid && (r_state == ST_IDLE);
    assign out_free    = !r_out_valid || !i_stall;

    assign o_valid       = r_out_valid;
    assign o_angle       = r_out_angle;
    assign o_angle_valid = r_out_avalid;
    assign o_finished    = r_out_fin;
    assign o_axis_out    = r_out_axis;

    // One restoring divider step: shift in the next dividend bit and try the subtract.
    assign trial    = {r_rem, r_num[NUM_BITS-1]};
    assign trial_ge = (trial >= {1'b0, r_duration});

    // Saturating tick counter value and the two endpoint gaps.
    assign tick_cnt = (r_count != {COUNT_BITS{1'b1}}) ? r_count + COUNT_BITS'(1) : r_count;
    assign gap_up   = r_target - i_current_angle;
    assign gap_down = i_current_angle - r_target;

    // Shared multiplier operand selection.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            ST_MUL_TT: begin
                mul_a = MA_BITS'(r_quo);
                mul_b = MB_BITS'(r_quo);
            end
            ST_MUL_S: begin
                mul_a = r_prod[MA_BITS-1:0];
                mul_b = THREE_ONE - {r_quo, 1'b0};
            end
            ST_MUL_MA: begin
                mul_a = MA_BITS'(r_start);
                mul_b = MB_BITS'(FRAC_ONE - r_prod[2*FRAC_BITS +: T_BITS]);
            end
            ST_MUL_MB: begin
                mul_a = MA_BITS'(r_end);
                mul_b = MB_BITS'(r_s);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p   = P_BITS'(mul_a) * P_BITS'(mul_b);
    assign mix_sum = r_acc + r_prod[ACC_BITS-1:0];

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duration <= '0;
            r_target   <= '0;
            r_axis     <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_DURATION: r_duration <= i_cfg_data;
                CFG_TARGET:   r_target   <= i_cfg_data[ANGLE_BITS-1:0];
                CFG_AXIS:     r_axis     <= i_cfg_data[0];
                default:      ;
            endcase
        end
    end

    // State and control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_start     <= '0;
            r_end       <= '0;
            r_count     <= '0;
            r_started   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_start     <= n_start;
            r_end       <= n_end;
            r_count     <= n_count;
            r_started   <= n_started;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath and payload registers.
    always_ff @(posedge i_clk) begin
        r_num        <= n_num;
        r_rem        <= n_rem;
        r_quo        <= n_quo;
        r_step       <= n_step;
        r_prod       <= n_prod;
        r_s          <= n_s;
        r_acc        <= n_acc;
        r_res_angle  <= n_res_angle;
        r_res_avalid <= n_res_avalid;
        r_res_fin    <= n_res_fin;
        r_out_angle  <= n_out_angle;
        r_out_avalid <= n_out_avalid;
        r_out_fin    <= n_out_fin;
        r_out_axis   <= n_out_axis;
    end

    // Sequencer: next state and datapath control.
    always_comb begin
        n_state      = r_state;
        n_start      = r_start;
        n_end        = r_end;
        n_count      = r_count;
        n_started    = r_started;
        n_num        = r_num;
        n_rem        = r_rem;
        n_quo        = r_quo;
        n_step       = r_step;
        n_prod       = r_prod;
        n_s          = r_s;
        n_acc        = r_acc;
        n_res_angle  = r_res_angle;
        n_res_avalid = r_res_avalid;
        n_res_fin    = r_res_fin;
        n_out_angle  = r_out_angle;
        n_out_avalid = r_out_avalid;
        n_out_fin    = r_out_fin;
        n_out_axis   = r_out_axis;
        n_out_valid  = r_out_valid && i_stall;

        unique case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    n_res_angle  = '0;
                    n_res_avalid = 1'b0;
                    n_res_fin    = 1'b0;
                    n_state      = ST_DONE;
                    if (i_func == FUNC_START) begin
                        // Add a full turn to the smaller endpoint if the gap is over half.
                        n_start   = PT_BITS'(i_current_angle);
                        n_end     = PT_BITS'(r_target);
                        if (i_current_angle < r_target && gap_up > HALF_TURN) begin
                            n_start = PT_BITS'(i_current_angle) + FULL_TURN;
                        end else if (r_target < i_current_angle && gap_down > HALF_TURN) begin
                            n_end = PT_BITS'(r_target) + FULL_TURN;
                        end
                        n_count   = '0;
                        n_started = 1'b1;
                    end else if (r_started) begin
                        n_count   = tick_cnt;
                        n_res_fin = (tick_cnt >= r_duration);
                        if (tick_cnt <= r_duration) begin
                            n_res_avalid = 1'b1;
                            n_num        = {tick_cnt, FRAC_BITS'(0)};
                            n_rem        = '0;
                            n_quo        = '0;
                            n_step       = '0;
                            n_state      = ST_DIV;
                        end
                    end
                end
            end
            ST_DIV: begin
                // One quotient bit per cycle.
                n_num = {r_num[NUM_BITS-2:0], 1'b0};
                n_quo = {r_quo[T_BITS-2:0], trial_ge};
                n_rem = trial_ge ? COUNT_BITS'(trial - {1'b0, r_duration})
                                 : trial[COUNT_BITS-1:0];
                n_step = r_step + STEP_BITS'(1);
                if (r_step == LAST_STEP) begin
                    n_state = ST_MUL_TT;
                end
            end
            ST_MUL_TT: begin
                n_prod  = mul_p;
                n_state = ST_MUL_S;
            end
            ST_MUL_S: begin
                n_prod  = mul_p;
                n_state = ST_MUL_MA;
            end
            ST_MUL_MA: begin
                // Keep s for the second mix term.
                n_s     = r_prod[2*FRAC_BITS +: T_BITS];
                n_prod  = mul_p;
                n_state = ST_MUL_MB;
            end
            ST_MUL_MB: begin
                n_acc   = r_prod[ACC_BITS-1:0];
                n_prod  = mul_p;
                n_state = ST_MIX;
            end
            ST_MIX: begin
                n_res_angle = mix_sum[FRAC_BITS +: ANGLE_BITS];
                n_state     = ST_DONE;
            end
            ST_DONE: begin
                // Move the result into the output register once it is free.
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_angle  = r_res_angle;
                    n_out_avalid = r_res_avalid;
                    n_out_fin    = r_res_fin;
                    n_out_axis   = r_axis;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule
